// File: rtl/atj_pkg.sv
// ----------------------------------------------------------------------------
// atj_pkg: shared types and constants of the tilt-to-joystick core.
// Holds the CORDIC word widths, the arctangent table and the cell payload.
// ----------------------------------------------------------------------------
package atj_pkg;

  localparam int TblLen         = 24;
  localparam int CordicStepsDef = 16;
  localparam int Frac           = 16;
  // Magnitude stays below 2^12 * 1.65 * 2^16, so 32 bits of x/y are plenty.
  localparam int Cw             = 32;
  localparam int Zw             = 24;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [10:0] ThreshReset = 11'd2023;

  // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
  function automatic logic [Zw-1:0] atan_deg(input logic [4:0] i);
    logic [Zw-1:0] v;
    case (i)
      5'd0:  v = 24'd2949120;
      5'd1:  v = 24'd1740967;
      5'd2:  v = 24'd919879;
      5'd3:  v = 24'd466945;
      5'd4:  v = 24'd234379;
      5'd5:  v = 24'd117304;
      5'd6:  v = 24'd58666;
      5'd7:  v = 24'd29335;
      5'd8:  v = 24'd14668;
      5'd9:  v = 24'd7334;
      5'd10: v = 24'd3667;
      5'd11: v = 24'd1833;
      5'd12: v = 24'd917;
      5'd13: v = 24'd458;
      5'd14: v = 24'd229;
      5'd15: v = 24'd115;
      5'd16: v = 24'd57;
      5'd17: v = 24'd29;
      5'd18: v = 24'd14;
      5'd19: v = 24'd7;
      5'd20: v = 24'd4;
      5'd21: v = 24'd2;
      5'd22: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Side information that rides along the cell chain with each sample.
  typedef struct packed {
    logic              ax_zero;
    logic              ax_neg;
    logic              button;
    logic [11:0]       ax_abs;
  } atj_side_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic signed [Cw-1:0] x;
    logic signed [Cw-1:0] y;
    logic signed [Zw-1:0] z;
    atj_side_t            side;
  } atj_cell_t;

endpackage

// File: rtl/atj_cell.sv
// ----------------------------------------------------------------------------
// atj_cell: one CORDIC iteration stage of the vectoring chain.
// MODE_DEG=0 steers by y>=0 (magnitude); MODE_DEG=1 steers by sign of y and
// accumulates the angle, doing nothing when y is zero.
// ----------------------------------------------------------------------------
module atj_cell #(
  parameter int STEP     = 0,
  parameter bit MODE_DEG = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  atj_pkg::atj_cell_t d_in,
  output logic               vld_out,
  output atj_pkg::atj_cell_t d_out
);
  import atj_pkg::*;

  logic               vld_r;
  atj_cell_t          d_r;
  atj_cell_t          d_nxt;
  logic signed [Cw-1:0] dx;
  logic signed [Cw-1:0] dy;

  // One rotation step.
  always_comb begin
    dx    = d_in.y >>> STEP;
    dy    = d_in.x >>> STEP;
    d_nxt = d_in;
    if (!MODE_DEG) begin
      if (!d_in.y[Cw-1]) begin
        d_nxt.x = d_in.x + dx;
        d_nxt.y = d_in.y - dy;
      end else begin
        d_nxt.x = d_in.x - dx;
        d_nxt.y = d_in.y + dy;
      end
    end else begin
      if (!d_in.y[Cw-1] && (d_in.y != '0)) begin
        d_nxt.x = d_in.x + dx;
        d_nxt.y = d_in.y - dy;
        d_nxt.z = d_in.z + $signed(atan_deg(5'(STEP)));
      end else if (d_in.y[Cw-1]) begin
        d_nxt.x = d_in.x - dx;
        d_nxt.y = d_in.y + dy;
        d_nxt.z = d_in.z - $signed(atan_deg(5'(STEP)));
      end
    end
  end

  // Stage register, held while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// File: rtl/accel_tilt_to_joystick_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_to_joystick_core: accelerometer pitch to joystick value.
//
// Input channel in_*: one transaction carries a sample, tdata holds accel_x,
// accel_y, accel_z (12 bits each, two's complement). Output channel out_*:
// tdata holds tilt_degrees (8 bits) and joystick_y (9 bits); tuser carries
// button_pressed. The cfg_* channel writes the 11-bit button threshold.
// The datapath is a chain of CORDIC cells: CORDIC_STEPS magnitude cells, a
// gain-multiply stage, an entry stage for the angle chain, CORDIC_STEPS angle
// cells and a final mapping register (CORDIC_STEPS is capped at TblLen).
// One sample is taken every cycle; the whole chain advances together, so
// throughput is one transaction per cycle while the receiver takes results.
// When out_tready is low the chain freezes and in_tready drops, unless the
// output register is empty. Reset empties the chain and loads the threshold
// with 2023.
// ----------------------------------------------------------------------------
module accel_tilt_to_joystick_core #(
  parameter int CORDIC_STEPS = atj_pkg::CordicStepsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // accel_x, accel_y, accel_z, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // tilt_degrees, joystick_y, zero pad
  output logic        out_tuser   // button_pressed
);
  import atj_pkg::*;

  localparam int N = (CORDIC_STEPS > TblLen) ? TblLen : CORDIC_STEPS;

  logic        en;
  logic [10:0] thresh_r;

  // Whole chain advances unless a valid result is stalled at the output.
  assign en        = !(out_tvalid && !out_tready);
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= ThreshReset;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  // Input decode into the first cell.
  logic signed [11:0] ax, ay, az;
  logic [11:0]        az_abs;
  atj_cell_t          c0;
  assign ax = in_tdata[11:0];
  assign ay = in_tdata[23:12];
  assign az = in_tdata[35:24];
  assign az_abs = az[11] ? 12'(-az) : 12'(az);

  always_comb begin
    c0                = '0;
    c0.x              = Cw'(az_abs) <<< Frac;
    c0.y              = Cw'(ay) <<< Frac;
    c0.side.ax_zero   = (ax == '0);
    c0.side.ax_neg    = ax[11];
    c0.side.ax_abs    = ax[11] ? 12'(-ax) : 12'(ax);
    c0.side.button    = $signed(az) > $signed({2'b00, thresh_r});
  end

  // Magnitude chain.
  logic      mv [N+1];
  atj_cell_t md [N+1];
  assign mv[0] = in_tvalid;
  assign md[0] = c0;

  for (genvar i = 0; i < N; i++) begin : g_mag
    atj_cell #(.STEP(i), .MODE_DEG(1'b0)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(mv[i]), .d_in(md[i]), .vld_out(mv[i+1]), .d_out(md[i+1])
    );
  end

  // Gain removal: clamp at zero, multiply by 1/K, keep the integer part.
  logic        gv_r;
  atj_side_t   gs_r;
  logic [61:0] prod_r;
  logic [Cw-2:0] xpos;
  assign xpos = md[N].x[Cw-1] ? '0 : md[N].x[Cw-2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= 1'b0;
    end else if (en) begin
      gv_r <= mv[N];
    end
    if (en) begin
      prod_r <= 62'(xpos) * 62'(InvGainQ30);
      gs_r   <= md[N].side;
    end
  end

  // Entry of the angle chain.
  logic      av [N+1];
  atj_cell_t ad [N+1];
  logic      ent_v_r;
  atj_cell_t ent_r;
  logic      rzero;
  logic [31:0] r;
  assign r = prod_r[61:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else if (en) begin
      ent_v_r <= gv_r;
    end
    if (en) begin
      ent_r.x    <= Cw'(r);
      ent_r.y    <= Cw'(gs_r.ax_abs) <<< Frac;
      ent_r.z    <= '0;
      ent_r.side <= gs_r;
    end
  end
  assign av[0] = ent_v_r;
  assign ad[0] = ent_r;

  // The zero-magnitude flag follows alongside; magnitude zero means x is 0.
  logic rz [N+1];
  assign rz[0] = (ent_r.x == '0);
  for (genvar i = 0; i < N; i++) begin : g_deg
    atj_cell #(.STEP(i), .MODE_DEG(1'b1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(av[i]), .d_in(ad[i]), .vld_out(av[i+1]), .d_out(ad[i+1])
    );
    logic rz_r;
    always_ff @(posedge clk) begin
      if (en) begin
        rz_r <= rz[i];
      end
    end
    assign rz[i+1] = rz_r;
  end
  assign rzero = rz[N];

  // Final clamp, sign, joystick mapping and output register.
  logic signed [7:0] deg_mag, deg;
  logic signed [Zw-1:0] zc;
  logic signed [19:0] jprod;
  logic [23:0]        jscl;
  logic [9:0]         jq;
  logic signed [8:0]  joy;
  logic        ov_r;
  logic [7:0]  deg_r;
  logic [8:0]  joy_r;
  logic        btn_r;

  always_comb begin
    zc = ad[N].z;
    if (zc < 0) zc = '0;
    if (zc > $signed(Zw'(90) <<< Frac)) zc = Zw'(90) <<< Frac;
    deg_mag = rzero ? 8'sd90 : 8'(zc >>> Frac);
    if (ad[N].side.ax_zero) deg_mag = '0;
    deg   = ad[N].side.ax_neg ? -deg_mag : deg_mag;
    // (deg+90)*510/180 = (deg+90)*17/6; the product is 0..3060, and
    // multiplying by 2731 then dropping 14 bits divides it by 6 exactly.
    jprod = 20'((20'(deg) + 20'sd90) * 20'sd17);
    jscl  = 24'(jprod[11:0]) * 24'd2731;
    jq    = jscl[23:14];
    joy   = ad[N].side.button ? 9'sd0 : 9'(jq - 10'd255);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= av[N];
    end
    if (en) begin
      deg_r <= deg;
      joy_r <= joy;
      btn_r <= ad[N].side.button;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, joy_r, deg_r};
  assign out_tuser  = btn_r;

endmodule
